// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the token scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Types, constants and helpers shared by the token scanner modules.
// ----------------------------------------------------------------------------
package pss_pkg;

   // Longest line, in characters, before the line is flagged as too long.
   localparam int MAX_LINE = 4096;
   localparam int POS_W    = $clog2(MAX_LINE + 1);

   // Classified character queue between the front and the scanner.
   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Result queue ahead of the response port.
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_QUOTE   = 8'd34;
   localparam logic [7:0] CH_DOT     = 8'd46;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_COLON   = 8'd58;
   localparam logic [7:0] CH_LT      = 8'd60;
   localparam logic [7:0] CH_EQ      = 8'd61;
   localparam logic [7:0] CH_GT      = 8'd62;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_UNDER   = 8'd95;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;

   localparam logic [3:0] KIND_WORD     = 4'd0;
   localparam logic [3:0] KIND_SYMBOL   = 4'd1;
   localparam logic [3:0] KIND_STRING   = 4'd2;
   localparam logic [3:0] KIND_INTEGER  = 4'd3;
   localparam logic [3:0] KIND_REAL     = 4'd4;
   localparam logic [3:0] KIND_BAD_INT  = 4'd5;
   localparam logic [3:0] KIND_BAD_REAL = 4'd6;
   localparam logic [3:0] KIND_OPEN_STR = 4'd7;
   localparam logic [3:0] KIND_EOL      = 4'd8;
   localparam logic [3:0] KIND_TOO_LONG = 4'd9;

   typedef struct packed {
      logic [7:0] char_code;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [11:0] token_start;
      logic [12:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      CLS_SEP,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_QUOTE,
      CLS_COLON,
      CLS_GT,
      CLS_LT,
      CLS_EQ,
      CLS_DOT,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic    line_end;
      cls_type cls;
   } item_type;

   typedef enum logic [8:0] {
      MODE_IDLE  = 9'b000000001,
      MODE_WORD  = 9'b000000010,
      MODE_INT   = 9'b000000100,
      MODE_REAL  = 9'b000001000,
      MODE_STR   = 9'b000010000,
      MODE_COLON = 9'b000100000,
      MODE_GT    = 9'b001000000,
      MODE_LT    = 9'b010000000,
      MODE_SKIP  = 9'b100000000
   } mode_type;

   // Up to two results written by the scanner in one cycle, first in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [11:0] to_start(input logic [POS_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[11:0];
   endfunction

   function automatic logic [12:0] to_len(input logic [POS_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[12:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [3:0] kind, input logic [11:0] start,
                                        input logic [12:0] len);
      rsp_type r;
      r.token_kind   = kind;
      r.token_start  = start;
      r.token_length = len;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/pss_front.sv =====
// ----------------------------------------------------------------------------
// pss_front
// Accepts characters and sorts each into a character class for the scanner.
// ----------------------------------------------------------------------------
module pss_front (
   input  logic              req_valid,
   input  pss_pkg::req_type  req_data,
   output logic              req_stall,
   input  logic              cq_full,
   output logic              cq_push,
   output pss_pkg::item_type cq_item
);
   import pss_pkg::*;

   logic [7:0] c;
   cls_type    cls;

   assign c         = req_data.char_code;
   assign req_stall = cq_full;
   assign cq_push   = req_valid & ~cq_full;

   always_comb begin
      priority if (c == CH_SPACE || c == CH_TAB) begin
         cls = CLS_SEP;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         cls = CLS_DIGIT;
      end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                   (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER) begin
         cls = CLS_ALPHA;
      end else if (c == CH_QUOTE) begin
         cls = CLS_QUOTE;
      end else if (c == CH_COLON) begin
         cls = CLS_COLON;
      end else if (c == CH_GT) begin
         cls = CLS_GT;
      end else if (c == CH_LT) begin
         cls = CLS_LT;
      end else if (c == CH_EQ) begin
         cls = CLS_EQ;
      end else if (c == CH_DOT) begin
         cls = CLS_DOT;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign cq_item.line_end = req_data.line_end;
   assign cq_item.cls      = cls;

endmodule

// ===== rtl/pss_queue.sv =====
// ----------------------------------------------------------------------------
// pss_queue
// Small first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module pss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pss_pkg::item_type push_item,
   input  logic              pop,
   output pss_pkg::item_type head_item,
   output logic              full,
   output logic              empty
);
   import pss_pkg::*;

   item_type              slot_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ff, wr_in;
   logic [CQ_PTR_W-1:0]   rd_ff, rd_in;
   logic [CQ_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + CQ_PTR_W'(1) : wr_ff;
      rd_in    = pop  ? rd_ff + CQ_PTR_W'(1) : rd_ff;
      count_in = count_ff + CQ_CNT_W'(push) - CQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/pss_scan.sv =====
// ----------------------------------------------------------------------------
// pss_scan
// Token state machine: consumes one classified character per cycle while one is
// queued and the result queue has room, and produces up to two results for it.
// ----------------------------------------------------------------------------
module pss_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  pss_pkg::item_type item,
   input  logic              room,
   output logic              pop,
   output pss_pkg::push_type push
);
   import pss_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pstart_ff, pstart_in;

   logic [POS_W-1:0] p;
   logic [POS_W-1:0] len;
   mode_type         bt_mode;
   logic [POS_W-1:0] bt_pstart;
   logic             bt_emit;
   rsp_type          sym_here;
   rsp_type          sym_pend;
   rsp_type          tok;
   logic             has_tok;
   rsp_type          r0, r1;
   logic [1:0]       n;

   assign pop      = item_valid & room;
   assign p        = pos_ff;
   assign len      = pos_ff - pstart_ff;
   assign sym_here = make_rsp(KIND_SYMBOL, to_start(p), 13'd1);
   assign sym_pend = make_rsp(KIND_SYMBOL, to_start(pstart_ff), 13'd1);

   // Start of a new token from the idle state, or after a word or symbol ends.
   always_comb begin
      bt_mode   = MODE_IDLE;
      bt_pstart = p;
      bt_emit   = 1'b0;
      unique case (item.cls)
         CLS_SEP:   bt_pstart = pstart_ff;
         CLS_QUOTE: begin
            bt_mode   = MODE_STR;
            bt_pstart = p + POS_W'(1);
         end
         CLS_COLON: bt_mode = MODE_COLON;
         CLS_GT:    bt_mode = MODE_GT;
         CLS_LT:    bt_mode = MODE_LT;
         CLS_DIGIT: bt_mode = MODE_INT;
         CLS_ALPHA: bt_mode = MODE_WORD;
         default:   bt_emit = 1'b1;
      endcase
   end

   // Token still pending when the line ends.
   always_comb begin
      has_tok = 1'b1;
      tok     = make_rsp(KIND_WORD, to_start(pstart_ff), to_len(len));
      unique case (mode_ff)
         MODE_WORD: tok.token_kind = KIND_WORD;
         MODE_INT:  tok.token_kind = KIND_INTEGER;
         MODE_REAL: tok.token_kind = KIND_REAL;
         MODE_STR:  tok.token_kind = KIND_OPEN_STR;
         MODE_COLON, MODE_GT, MODE_LT: tok = sym_pend;
         default:   has_tok = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      n         = 2'd0;
      r0        = '0;
      r1        = '0;
      if (item.line_end) begin
         if (has_tok) begin
            r0 = tok;
            r1 = make_rsp(KIND_EOL, 12'd0, to_len(p));
            n  = 2'd2;
         end else begin
            r0 = make_rsp(KIND_EOL, 12'd0, to_len(p));
            n  = 2'd1;
         end
         mode_in   = MODE_IDLE;
         pos_in    = '0;
         pstart_in = '0;
      end else if (p >= POS_W'(MAX_LINE)) begin
         if (mode_ff != MODE_SKIP) begin
            mode_in = MODE_SKIP;
            r0      = make_rsp(KIND_TOO_LONG, 12'd0, 13'd0);
            n       = 2'd1;
         end
      end else begin
         pos_in = p + POS_W'(1);
         unique case (mode_ff)
            MODE_IDLE: begin
               mode_in   = bt_mode;
               pstart_in = bt_pstart;
               r0        = sym_here;
               n         = bt_emit ? 2'd1 : 2'd0;
            end
            MODE_WORD: begin
               if (item.cls != CLS_ALPHA && item.cls != CLS_DIGIT) begin
                  r0        = make_rsp(KIND_WORD, to_start(pstart_ff), to_len(len));
                  r1        = sym_here;
                  n         = bt_emit ? 2'd2 : 2'd1;
                  mode_in   = bt_mode;
                  pstart_in = bt_pstart;
               end
            end
            MODE_INT, MODE_REAL: begin
               if (item.cls == CLS_DIGIT) begin
                  mode_in = mode_ff;
               end else if (mode_ff == MODE_INT && item.cls == CLS_DOT) begin
                  mode_in = MODE_REAL;
               end else if (item.cls == CLS_SEP) begin
                  r0 = make_rsp((mode_ff == MODE_INT) ? KIND_INTEGER : KIND_REAL,
                                to_start(pstart_ff), to_len(len));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  r0 = make_rsp((mode_ff == MODE_INT) ? KIND_BAD_INT : KIND_BAD_REAL,
                                to_start(pstart_ff), to_len(len));
                  n       = 2'd1;
                  mode_in = MODE_SKIP;
               end
            end
            MODE_STR: begin
               if (item.cls == CLS_QUOTE) begin
                  r0      = make_rsp(KIND_STRING, to_start(pstart_ff), to_len(len));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_COLON, MODE_GT, MODE_LT: begin
               if (item.cls == CLS_EQ || (mode_ff == MODE_LT && item.cls == CLS_GT)) begin
                  r0      = make_rsp(KIND_SYMBOL, to_start(pstart_ff), 13'd2);
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  r0        = sym_pend;
                  r1        = sym_here;
                  n         = bt_emit ? 2'd2 : 2'd1;
                  mode_in   = bt_mode;
                  pstart_in = bt_pstart;
               end
            end
            default: mode_in = MODE_SKIP;
         endcase
      end
      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = (n == 2'd2);
   end

   assign push.count  = pop ? n : 2'd0;
   assign push.first  = r0;
   assign push.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
      end else if (pop) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
      end
   end

endmodule

// ===== rtl/pss_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// pss_rsp_queue
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module pss_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  pss_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pss_pkg::rsp_type  rsp_data
);
   import pss_pkg::*;

   rsp_type             slot_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ff, wr_in;
   logic [RQ_PTR_W-1:0] rd_ff, rd_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;
   logic [RQ_PTR_W-1:0] wr_next;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   // Two free entries are needed before the scanner may take a character.
   assign room      = (count_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign wr_next   = wr_ff + RQ_PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + RQ_PTR_W'(push.count);
      rd_in    = pop ? rd_ff + RQ_PTR_W'(1) : rd_ff;
      count_in = count_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== rtl/pascal_style_token_scanner.sv =====
// ----------------------------------------------------------------------------
// pascal_style_token_scanner
// Splits a line of characters into tokens and reports class, offset, length.
// ----------------------------------------------------------------------------
// Usage: one character word enters on the req_ channel per accepted cycle; a
// word with line_end set closes the line. Each input word causes zero, one or
// two result words on the rsp_ channel, and the last result of a word carries
// last_of_run. A word is accepted when req_valid is high and req_stall is low;
// a result is taken when rsp_valid is high and rsp_stall is low.
// When the queues are empty, an accepted character is written to the
// character queue, is then scanned, and its results are written to the result
// queue, which raises rsp_valid. Throughput is one character per cycle while
// the result queue has two free entries, limited by the scanner state machine,
// which handles one character per cycle; long runs of characters that yield
// two results drain at one result per cycle.
// While the receiver stalls, results collect in a four-entry result queue and
// then characters collect in a four-entry character queue; once that fills,
// req_stall rises. Synchronous reset empties both queues and returns the
// scanner to the start of a line with the position counter at zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pascal_style_token_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pss_pkg::rsp_type rsp_data
);
   import pss_pkg::*;

   // Front to queue: classified characters.
   logic     cq_push;
   item_type cq_item;
   logic     cq_full;
   logic     cq_empty;
   item_type cq_head;

   // Queue to scanner to result queue.
   logic     cq_pop;
   logic     rq_room;
   push_type scan_push;

   // The front classifies each character combinationally and writes it to the
   // character queue; it stalls the requester only when that queue is full.
   pss_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .cq_full   (cq_full),
      .cq_push   (cq_push),
      .cq_item   (cq_item)
   );

   pss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_item (cq_item),
      .pop       (cq_pop),
      .head_item (cq_head),
      .full      (cq_full),
      .empty     (cq_empty)
   );

   // The scanner takes a character only when two result slots are free, so
   // a character never has to be split across cycles.
   pss_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (~cq_empty),
      .item       (cq_head),
      .room       (rq_room),
      .pop        (cq_pop),
      .push       (scan_push)
   );

   pss_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_push),
      .room      (rq_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The scanner only writes results when the result queue has room for both.
   `ASSERT_IMPLIES(a_rsp_no_overflow, clock, reset, scan_push.count != 2'd0, rq_room)
   // Characters are only consumed from a non-empty queue.
   `ASSERT_IMPLIES(a_cq_no_underflow, clock, reset, cq_pop, !cq_empty)
   // A single result is always the final one of its character.
   `ASSERT_IMPLIES(a_single_is_last, clock, reset, scan_push.count == 2'd1, scan_push.first.last_of_run)
   // Reset leaves the result port idle.
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule
